/* src/cmfs_pkg.sv */
// Shared constants, codes and types for the cube map face select core.
`timescale 1ns / 1ps
`default_nettype none
package cmfs_pkg;

    localparam int IN_W           = 24;
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 20;
    localparam int VS_W           = 24;
    localparam int VS_FRAC        = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [VS_W-1:0] VS_RESET = VS_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANAR_MODE = 2'd0,
        CFG_VIEW_SCALE  = 2'd1
    } cfg_idx_t;

    localparam logic [2:0] FACE_NEG_Z = 3'd0;
    localparam logic [2:0] FACE_POS_Z = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_X = 3'd3;
    localparam logic [2:0] FACE_NEG_Y = 3'd4;
    localparam logic [2:0] FACE_POS_X = 3'd5;

    // Per-item data that rides along the divider pipeline untouched
    typedef struct packed {
        logic [2:0]      face;
        logic            degen;
        logic [IN_W-1:0] dx_first;
        logic [IN_W-1:0] dx_second;
        logic [IN_W-1:0] dy_first;
        logic [IN_W-1:0] dy_second;
    } side_t;

endpackage
`default_nettype wire

/* src/cube_map_face_select_core.sv */
// Top level: cube map face select with pipelined coordinate dividers.
//
// Usage: one direction plus two screen derivative vectors enter on the s_axis
// channel (s_tvalid/s_tready/s_tdata); one result leaves on the m_axis channel
// per item (face, coord_u, coord_v, four face derivative components in tdata,
// the degenerate flag in tuser). Configuration (planar_mode, view_scale) is
// written over cfg_valid/cfg_addr/cfg_data (always ready); the user must write it
// only while the block is idle, which the block does not enforce. Registers, in
// order: face select and planar scale multiply, sign fix and sum, numerator build,
// then one restoring divider step per quotient bit (overflow check first), then
// saturation into the output register. Throughput is one item per cycle unless
// m_tready stalls the pipeline; the two coordinate dividers run side by side.
// Reset clears all valid bits and sets planar_mode = 0, view_scale = 1.0.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated, and flow resumes the cycle
// m_tready returns.
`timescale 1ns / 1ps
`default_nettype none
module cube_map_face_select_core #(
    parameter int COORD_BITS = cmfs_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cmfs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // cfg: register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmfs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [cmfs_pkg::VS_W-1:0]         cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: dir_x, dir_y, dir_z, dx_x, dx_y, dx_z, dy_x, dy_y, dy_z (24 bits each)
    input  wire logic [9*cmfs_pkg::IN_W-1:0]       s_tdata,
    // output stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: face[3], coord_u, coord_v, face_dx_first, face_dx_second,
    //          face_dy_first, face_dy_second, zero fill
    output logic [((99+2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    // m_tuser: degenerate
    output logic                                   m_tuser
);
    import cmfs_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((99 + 2*COORD_BITS + 7) / 8) * 8;
    localparam int DENW  = 41;                 // |den| <= 2^39
    localparam int NUW   = 49;                 // |view_scale * dir| < 2^47
    localparam int SW    = 50;                 // den + nu
    localparam int NW    = SW + FRAC_BITS + 1; // s * 2^F + den
    localparam int DW    = DENW + 1;           // 2 * den
    localparam int CW0   = (NW > DW + CB) ? NW : DW + CB;
    localparam int CW    = CW0 + 1;
    localparam int DS    = CB;                 // overflow step + CB-1 bit steps
    localparam logic [CB-1:0] HALF = (FRAC_BITS >= COORD_BITS) ?
                                     {1'b0, {(CB-1){1'b1}}} :
                                     CB'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [CW-1:0]   rem;
        logic [DW-1:0]   dvs;
        logic [CB-2:0]   quo;
        logic            ovf;
        logic            neg;
    } lane_t;

    // ---------------- configuration ----------------
    logic            planar_reg;
    logic [VS_W-1:0] view_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planar_reg     <= 1'b0;
            view_scale_reg <= VS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_PLANAR_MODE: planar_reg     <= cfg_data[0];
                CFG_VIEW_SCALE:  view_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic          m_valid_reg;
    logic          en;
    logic          v1_reg, v2_reg, v3_reg;
    logic [DS-1:0] dv_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            dv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            dv_reg      <= {dv_reg[DS-2:0], v3_reg};
            m_valid_reg <= dv_reg[DS-1];
        end
    end

    // ---------------- stage 1: face select, planar multiply ----------------
    logic signed [IN_W-1:0] dir_x, dir_y, dir_z;
    logic signed [IN_W:0]   x25, y25, z25, ax, ay, nax, nay;
    logic signed [IN_W:0]   vs25;
    logic signed [2*IN_W+1:0] prod_x, prod_y;
    logic [2:0]             face_c;
    logic signed [DENW-1:0] den_c;
    logic signed [NUW-1:0]  nu_c, nv_c;
    side_t                  side_c;

    assign dir_x  = s_tdata[0*IN_W +: IN_W];
    assign dir_y  = s_tdata[1*IN_W +: IN_W];
    assign dir_z  = s_tdata[2*IN_W +: IN_W];
    assign x25    = {dir_x[IN_W-1], dir_x};
    assign y25    = {dir_y[IN_W-1], dir_y};
    assign z25    = {dir_z[IN_W-1], dir_z};
    assign ax     = x25[IN_W] ? -x25 : x25;
    assign ay     = y25[IN_W] ? -y25 : y25;
    assign nax    = -ax;
    assign nay    = -ay;
    assign vs25   = signed'({1'b0, view_scale_reg});
    assign prod_x = vs25 * x25;
    assign prod_y = vs25 * y25;

    always_comb
    begin
        if (planar_reg)
        begin
            face_c = FACE_POS_Z;
            den_c  = DENW'({z25, {VS_FRAC{1'b0}}});
            nu_c   = prod_x[NUW-1:0];
            nv_c   = prod_y[NUW-1:0];
        end
        else if (z25 <= nax && z25 <= nay)
        begin
            face_c = FACE_NEG_Z;
            den_c  = DENW'(-z25);
            nu_c   = NUW'(x25);
            nv_c   = NUW'(y25);
        end
        else if (z25 >= ax && z25 >= ay)
        begin
            face_c = FACE_POS_Z;
            den_c  = DENW'(z25);
            nu_c   = NUW'(x25);
            nv_c   = NUW'(-y25);
        end
        else if (y25 >= ax)
        begin
            face_c = FACE_POS_Y;
            den_c  = DENW'(y25);
            nu_c   = NUW'(x25);
            nv_c   = NUW'(z25);
        end
        else if (x25 <= nay)
        begin
            face_c = FACE_NEG_X;
            den_c  = DENW'(-x25);
            nu_c   = NUW'(y25);
            nv_c   = NUW'(z25);
        end
        else if (y25 <= nax)
        begin
            face_c = FACE_NEG_Y;
            den_c  = DENW'(-y25);
            nu_c   = NUW'(-x25);
            nv_c   = NUW'(z25);
        end
        else
        begin
            face_c = FACE_POS_X;
            den_c  = DENW'(x25);
            nu_c   = NUW'(-y25);
            nv_c   = NUW'(z25);
        end
    end

    always_comb
    begin
        side_c.face  = face_c;
        side_c.degen = 1'b0;
        case (face_c)
            FACE_POS_Y, FACE_NEG_Y:
            begin
                side_c.dx_first  = s_tdata[3*IN_W +: IN_W];
                side_c.dx_second = s_tdata[5*IN_W +: IN_W];
                side_c.dy_first  = s_tdata[6*IN_W +: IN_W];
                side_c.dy_second = s_tdata[8*IN_W +: IN_W];
            end
            FACE_NEG_X, FACE_POS_X:
            begin
                side_c.dx_first  = s_tdata[4*IN_W +: IN_W];
                side_c.dx_second = s_tdata[5*IN_W +: IN_W];
                side_c.dy_first  = s_tdata[7*IN_W +: IN_W];
                side_c.dy_second = s_tdata[8*IN_W +: IN_W];
            end
            default:
            begin
                side_c.dx_first  = s_tdata[3*IN_W +: IN_W];
                side_c.dx_second = s_tdata[4*IN_W +: IN_W];
                side_c.dy_first  = s_tdata[6*IN_W +: IN_W];
                side_c.dy_second = s_tdata[7*IN_W +: IN_W];
            end
        endcase
    end

    side_t                  side1_reg;
    logic                   planar1_reg;
    logic signed [DENW-1:0] den1_reg;
    logic signed [NUW-1:0]  nu1_reg, nv1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg   <= side_c;
            planar1_reg <= planar_reg;
            den1_reg    <= den_c;
            nu1_reg     <= nu_c;
            nv1_reg     <= nv_c;
        end
    end

    // ---------------- stage 2: sign fix, numerator sums ----------------
    logic                   den_neg;
    logic signed [DENW-1:0] den_a;
    logic signed [NUW-1:0]  nu_a, nv_a;
    side_t                  side2_c;

    assign den_neg = den1_reg[DENW-1];
    assign den_a   = den_neg ? -den1_reg : den1_reg;
    // planar v is -(s*y), then the whole ratio flips when z < 0
    assign nu_a    = (planar1_reg && den_neg) ? -nu1_reg : nu1_reg;
    assign nv_a    = (planar1_reg && !den_neg) ? -nv1_reg : nv1_reg;

    always_comb
    begin
        side2_c       = side1_reg;
        side2_c.degen = (den_a == '0);
    end

    side_t                  side2_reg;
    logic signed [DENW-1:0] den2_reg;
    logic signed [SW-1:0]   su2_reg, sv2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side2_c;
            den2_reg  <= den_a;
            su2_reg   <= SW'(den_a) + SW'(nu_a);
            sv2_reg   <= SW'(den_a) + SW'(nv_a);
        end
    end

    // ---------------- stage 3: dividend and divisor ----------------
    // floor(N / D) with N < 0 is ~floor(~N / D), so both lanes divide magnitudes
    logic signed [NW-1:0] n_u, n_v;
    lane_t                lane_u_c, lane_v_c;

    assign n_u = (NW'(su2_reg) <<< FRAC_BITS) + NW'(den2_reg);
    assign n_v = (NW'(sv2_reg) <<< FRAC_BITS) + NW'(den2_reg);

    always_comb
    begin
        lane_u_c     = '0;
        lane_u_c.neg = n_u[NW-1];
        lane_u_c.rem = CW'(n_u[NW-1] ? ~n_u : n_u);
        lane_u_c.dvs = {den2_reg, 1'b0};
        lane_v_c     = '0;
        lane_v_c.neg = n_v[NW-1];
        lane_v_c.rem = CW'(n_v[NW-1] ? ~n_v : n_v);
        lane_v_c.dvs = {den2_reg, 1'b0};
    end

    side_t side3_reg;
    lane_t lane_u3_reg, lane_v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg   <= side2_reg;
            lane_u3_reg <= lane_u_c;
            lane_v3_reg <= lane_v_c;
        end
    end

    // ---------------- divider: one step per stage ----------------
    side_t side_d_reg [DS];
    lane_t lane_u_reg [DS];
    lane_t lane_v_reg [DS];

    function automatic lane_t div_step(lane_t l, int k, logic first);
        logic [CW-1:0] sd;
        lane_t         r;
        sd = CW'(l.dvs) << k;
        r  = l;
        if (first)
            r.ovf = (l.rem >= sd);
        else if (!l.ovf && l.rem >= sd)
        begin
            r.rem    = l.rem - sd;
            r.quo[k] = 1'b1;
        end
        return r;
    endfunction

    genvar j;
    generate
        for (j = 0; j < DS; j++)
        begin : g_div
            if (j == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        side_d_reg[j] <= side3_reg;
                        lane_u_reg[j] <= div_step(lane_u3_reg, CB - 1, 1'b1);
                        lane_v_reg[j] <= div_step(lane_v3_reg, CB - 1, 1'b1);
                    end
                end
            end
            else
            begin : g_step
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        side_d_reg[j] <= side_d_reg[j-1];
                        lane_u_reg[j] <= div_step(lane_u_reg[j-1], CB - 1 - j, 1'b0);
                        lane_v_reg[j] <= div_step(lane_v_reg[j-1], CB - 1 - j, 1'b0);
                    end
                end
            end
        end
    endgenerate

    // ---------------- output stage: saturate, sign, degenerate ----------------
    function automatic logic [CB-1:0] finish(lane_t l, logic degen);
        logic [CB-1:0] mag;
        mag = {1'b0, (l.ovf ? {(CB-1){1'b1}} : l.quo)};
        if (degen)
            return HALF;
        return l.neg ? ~mag : mag;
    endfunction

    side_t         side_o_reg;
    logic [CB-1:0] cu_reg, cv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_o_reg <= side_d_reg[DS-1];
            cu_reg     <= finish(lane_u_reg[DS-1], side_d_reg[DS-1].degen);
            cv_reg     <= finish(lane_v_reg[DS-1], side_d_reg[DS-1].degen);
        end
    end

    assign m_tdata = OUT_W'({side_o_reg.dy_second, side_o_reg.dy_first,
                             side_o_reg.dx_second, side_o_reg.dx_first,
                             cv_reg, cu_reg, side_o_reg.face});
    assign m_tuser = side_o_reg.degen;

    // ---------------- assertions ----------------
    a_face_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> side_o_reg.face <= FACE_POS_X)
        else $error("illegal face code on output");

    a_degen_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && side_o_reg.degen |-> cu_reg == HALF && cv_reg == HALF)
        else $error("degenerate result without center coordinates");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_reg) && $stable(v3_reg) && $stable(v1_reg))
        else $error("pipeline moved during stall");

    a_planar_face: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && planar1_reg |-> side1_reg.face == FACE_POS_Z)
        else $error("planar item not on face 1");

endmodule
`default_nettype wire

/* sim/cube_map_face_select_core_test.sv */
// Self-checking testbench for the cube map face select core: directed table plus random traffic.
`timescale 1ns / 1ps
`default_nettype none
module cube_map_face_select_core_test;
    import cmfs_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int OUT_W     = ((99 + 2 * CB + 7) / 8) * 8;
    localparam int LATENCY   = CB + 4;
    localparam int DRAIN     = LATENCY + 12;
    localparam int STALL_MAX = 20000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;

    localparam logic signed [23:0] ONE  = 24'sd1048576;
    localparam logic signed [23:0] HALF = 24'sd524288;
    localparam logic signed [23:0] MAXV = 24'sh7FFFFF;
    localparam logic signed [23:0] MINV = 24'sh800000;

    typedef logic signed [IN_W-1:0] vec9_t [9];

    typedef struct packed {
        logic [2:0]             face;
        logic signed [CB-1:0]   u;
        logic signed [CB-1:0]   v;
        logic [IN_W-1:0]        d1;
        logic [IN_W-1:0]        d2;
        logic [IN_W-1:0]        e1;
        logic [IN_W-1:0]        e2;
        logic                   degen;
    } face_result_t;

    typedef struct {
        vec9_t                  comp;
        bit                     typed;
        logic [2:0]             face;
        logic signed [CB-1:0]   u;
        logic signed [CB-1:0]   v;
        logic                   degen;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [VS_W-1:0]        cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [9*IN_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   m_tuser;

    cube_map_face_select_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // predictor copy of the configuration
    logic                   planar_q = 1'b0;
    logic [VS_W-1:0]        scale_q  = VS_RESET;

    face_result_t           pending_faces[$];
    int                     errors = 0;
    int                     results_seen = 0;
    int                     idle_cycles = 0;
    bit                     sender_fast = 1'b0;

    // floor((s * 2^FB + d) / (2d)), saturated to the coordinate range
    function automatic logic signed [CB-1:0] tex_coord(longint s, longint d);
        logic signed [127:0] num;
        logic signed [127:0] div2;
        logic signed [127:0] q;
        num  = s;
        num  = (num <<< FB) + d;
        div2 = 2 * d;
        q    = num / div2;
        if (num < 0 && q * div2 != num)
            q = q - 1;
        if (q > (2 ** (CB - 1)) - 1)
            q = (2 ** (CB - 1)) - 1;
        if (q < -(2 ** (CB - 1)))
            q = -(2 ** (CB - 1));
        return q[CB-1:0];
    endfunction

    function automatic face_result_t predict_face(vec9_t c);
        face_result_t r;
        longint x, y, z, ax, ay, den, nu, nv;
        x  = c[0];
        y  = c[1];
        z  = c[2];
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (planar_q)
        begin
            r.face = FACE_POS_Z;
            den = z * 65536;
            nu  = longint'(scale_q) * x;
            nv  = -(longint'(scale_q) * y);
            if (den < 0)
            begin
                den = -den;
                nu  = -nu;
                nv  = -nv;
            end
        end
        else if (z <= -ax && z <= -ay)
        begin
            r.face = FACE_NEG_Z; den = -z; nu = x;  nv = y;
        end
        else if (z >= ax && z >= ay)
        begin
            r.face = FACE_POS_Z; den = z;  nu = x;  nv = -y;
        end
        else if (y >= ax)
        begin
            r.face = FACE_POS_Y; den = y;  nu = x;  nv = z;
        end
        else if (x <= -ay)
        begin
            r.face = FACE_NEG_X; den = -x; nu = y;  nv = z;
        end
        else if (y <= -ax)
        begin
            r.face = FACE_NEG_Y; den = -y; nu = -x; nv = z;
        end
        else
        begin
            r.face = FACE_POS_X; den = x;  nu = -y; nv = z;
        end
        r.degen = (den <= 0);
        if (r.degen)
        begin
            r.u = CB'(1 <<< (FB - 1));
            r.v = CB'(1 <<< (FB - 1));
        end
        else
        begin
            r.u = tex_coord(den + nu, den);
            r.v = tex_coord(den + nv, den);
        end
        if (r.face == FACE_POS_Y || r.face == FACE_NEG_Y)
        begin
            r.d1 = c[3]; r.d2 = c[5]; r.e1 = c[6]; r.e2 = c[8];
        end
        else if (r.face == FACE_NEG_X || r.face == FACE_POS_X)
        begin
            r.d1 = c[4]; r.d2 = c[5]; r.e1 = c[7]; r.e2 = c[8];
        end
        else
        begin
            r.d1 = c[3]; r.d2 = c[4]; r.e1 = c[6]; r.e2 = c[7];
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VS_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PLANAR_MODE)
            planar_q = val[0];
        else if (idx == CFG_VIEW_SCALE)
            scale_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender pauses until every expected result is back, then lets the pipe drain
    task automatic wait_drained();
        while (pending_faces.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic send_dir(vec9_t c, bit typed, face_result_t typed_res);
        int gap;
        face_result_t r;
        logic [9*IN_W-1:0] word;
        gap = 0;
        if (!sender_fast)
        begin
            if ($urandom_range(0, 49) == 0)
                gap = $urandom_range(20, 60);
            else if ($urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        for (int i = 0; i < 9; i++)
            word[i*IN_W +: IN_W] = c[i];
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_face(c);
        if (typed)
        begin
            r.face  = typed_res.face;
            r.u     = typed_res.u;
            r.v     = typed_res.v;
            r.degen = typed_res.degen;
        end
        pending_faces.push_back(r);
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return 24'sd1;
            3: return -24'sd1;
            4: return ONE;
            default: return '0;
        endcase
    endfunction

    function automatic vec9_t random_dir();
        vec9_t c;
        int kind;
        logic signed [IN_W-1:0] m;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            c[i] = IN_W'($urandom());
        if (kind == 4 || kind == 5)
        begin
            for (int i = 0; i < 3; i++)
                c[i] = IN_W'($signed($urandom_range(0, 8192)) - 4096);
        end
        else if (kind == 6)
        begin
            // equal magnitudes on several axes to hit the tie rules
            m = IN_W'($urandom_range(0, 8388607));
            for (int i = 0; i < 3; i++)
                if ($urandom_range(0, 3) != 0)
                    c[i] = $urandom_range(0, 1) ? m : -m;
        end
        else if (kind == 7)
        begin
            for (int i = 0; i < 3; i++)
                c[i] = IN_W'($signed($urandom_range(0, 65536)) - 32768);
            c[$urandom_range(0, 2)] = IN_W'($urandom());
        end
        else if (kind == 8)
        begin
            for (int i = 0; i < 3; i++)
                if ($urandom_range(0, 1) == 0)
                    c[i] = '0;
        end
        else if (kind == 9)
        begin
            for (int i = 0; i < 9; i++)
                c[i] = pick_extreme();
        end
        return c;
    endfunction

    task automatic random_phase(int count);
        face_result_t none;
        none = '{default: '0};
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                sender_fast = ($urandom_range(0, 2) == 0);
            send_dir(random_dir(), 1'b0, none);
        end
        end_burst();
    endtask

    function automatic stim_row_t make_row(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                                           logic signed [IN_W-1:0] z, int k, bit typed,
                                           logic [2:0] face, logic signed [CB-1:0] u,
                                           logic signed [CB-1:0] v, logic degen);
        stim_row_t r;
        r.comp[0] = x;
        r.comp[1] = y;
        r.comp[2] = z;
        // odd rows: distinct derivative values so a wrong selection shows; even rows: MAXV/MINV
        for (int i = 3; i < 9; i++)
            r.comp[i] = (k % 2 == 0) ? ((i % 2 == 0) ? MAXV : MINV) : 24'(i * 24'h111111 + k);
        r.typed = typed;
        r.face  = face;
        r.u     = u;
        r.v     = v;
        r.degen = degen;
        return r;
    endfunction

    stim_row_t directed[$];

    initial
    begin
        face_result_t tr;
        directed.push_back(make_row(0, 0, 0, 0, 1, FACE_NEG_Z, HALF, HALF, 1));
        directed.push_back(make_row(0, 0, ONE, 1, 1, FACE_POS_Z, HALF, HALF, 0));
        directed.push_back(make_row(0, 0, -ONE, 2, 1, FACE_NEG_Z, HALF, HALF, 0));
        directed.push_back(make_row(0, ONE, 0, 3, 1, FACE_POS_Y, HALF, HALF, 0));
        directed.push_back(make_row(-ONE, 0, 0, 4, 1, FACE_NEG_X, HALF, HALF, 0));
        directed.push_back(make_row(0, -ONE, 0, 5, 1, FACE_NEG_Y, HALF, HALF, 0));
        directed.push_back(make_row(ONE, 0, 0, 6, 1, FACE_POS_X, HALF, HALF, 0));
        directed.push_back(make_row(ONE, ONE, ONE, 7, 0, 0, 0, 0, 0));
        directed.push_back(make_row(-ONE, -ONE, -ONE, 8, 0, 0, 0, 0, 0));
        directed.push_back(make_row(MAXV, MAXV, MAXV, 9, 0, 0, 0, 0, 0));
        directed.push_back(make_row(MINV, MINV, MINV, 10, 0, 0, 0, 0, 0));
        directed.push_back(make_row(MAXV, MINV, 0, 11, 0, 0, 0, 0, 0));
        directed.push_back(make_row(MINV, MAXV, MINV, 12, 0, 0, 0, 0, 0));
        directed.push_back(make_row(1, 0, 0, 13, 0, 0, 0, 0, 0));
        directed.push_back(make_row(-1, 1, 0, 14, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ONE, -ONE, 0, 15, 0, 0, 0, 0, 0));
        directed.push_back(make_row(-ONE, ONE, 0, 16, 0, 0, 0, 0, 0));
        directed.push_back(make_row(MINV, 1, MAXV, 17, 0, 0, 0, 0, 0));
        directed.push_back(make_row(3, -7, 5, 18, 0, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            tr       = '{default: '0};
            tr.face  = directed[i].face;
            tr.u     = directed[i].u;
            tr.v     = directed[i].v;
            tr.degen = directed[i].degen;
            send_dir(directed[i].comp, directed[i].typed, tr);
        end
        end_burst();
        random_phase(300);

        wait_drained();
        write_reg(CFG_PLANAR_MODE, 1);
        // planar zero divisor
        tr = '{default: '0};
        tr.face  = FACE_POS_Z;
        tr.u     = HALF;
        tr.v     = HALF;
        tr.degen = 1'b1;
        send_dir(make_row(ONE, ONE, 0, 0, 1, FACE_POS_Z, HALF, HALF, 1).comp, 1'b1, tr);
        end_burst();
        random_phase(200);

        wait_drained();
        write_reg(CFG_VIEW_SCALE, 24'hFFFFFF);
        random_phase(180);

        wait_drained();
        write_reg(CFG_VIEW_SCALE, 24'h000000);
        random_phase(120);

        wait_drained();
        write_reg(CFG_VIEW_SCALE, 24'h003A5C);
        random_phase(150);

        wait_drained();
        write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
        write_reg(CFG_PLANAR_MODE, 0);
        random_phase(180);

        wait_drained();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random back-pressure with one long hold-off
    initial
    begin
        int r;
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (!held && results_seen >= 150)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (r < 5)
            begin
                m_tready <= 1'b1;
                repeat (40) @(negedge clk);
            end
            else if (r < 8)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 50)) @(negedge clk);
            end
            else if (r < 30)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        face_result_t got, exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.face  = m_tdata[2:0];
            got.u     = m_tdata[3 +: CB];
            got.v     = m_tdata[3 + CB +: CB];
            got.d1    = m_tdata[3 + 2 * CB +: IN_W];
            got.d2    = m_tdata[3 + 2 * CB + IN_W +: IN_W];
            got.e1    = m_tdata[3 + 2 * CB + 2 * IN_W +: IN_W];
            got.e2    = m_tdata[3 + 2 * CB + 3 * IN_W +: IN_W];
            got.degen = m_tuser;
            if (pending_faces.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with nothing expected (face %0d)", $time,
                         got.face);
            end
            else
            begin
                exp_r = pending_faces.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    $display("%0t: mismatch exp face %0d u %h v %h d %h %h %h %h dg %b",
                             $time, exp_r.face, exp_r.u, exp_r.v, exp_r.d1, exp_r.d2,
                             exp_r.e1, exp_r.e2, exp_r.degen);
                    $display("%0t:          act face %0d u %h v %h d %h %h %h %h dg %b",
                             $time, got.face, got.u, got.v, got.d1, got.d2,
                             got.e1, got.e2, got.degen);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
`default_nettype wire
